// ===== src/pac_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the polygon area and centroid block
package pac_pkg;

	localparam int COORD_W   = 16;
	localparam int PROD_W    = 32;
	localparam int PAIR_W    = 17;
	localparam int CROSS_W   = 33;
	localparam int MOMP_W    = 50;
	localparam int AREA_W    = 42;
	localparam int MOM_W     = 58;
	localparam int TOL_W     = 33;
	localparam int D3_W      = 43;
	localparam int DEN_W     = 44;
	localparam int NUM_W     = 60;
	localparam int AREA_OUT_W = 32;
	localparam int DIV_STEPS = NUM_W;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_LOW_AREA = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic                      last_vertex;
	} vertex_t;

	typedef struct packed {
		logic [AREA_OUT_W-1:0]     area;
		logic signed [COORD_W-1:0] centroid_x;
		logic signed [COORD_W-1:0] centroid_y;
		logic [1:0]                status;
	} result_t;

	typedef struct packed {
		logic    load_first;
		logic    load_cur;
		logic    shift_prev;
		logic    use_close;
		logic    mul;
		logic    xprod;
		logic    mom;
		logic    acc;
		logic    check;
		logic    div_load;
		logic    div_sel_y;
		logic    div_step;
		logic    store_x;
		logic    store_y;
		logic    clear;
		status_t status;
	} pac_cmd_t;

	typedef struct packed {
		logic low_area;
	} pac_stat_t;

endpackage

// ===== src/pac_div.sv =====
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle while step is high, with signed 16-bit integer saturation
module pac_div
	import pac_pkg::*;
(
	input  logic                      clk,
	input  logic                      load,
	input  logic                      step,
	input  logic [NUM_W-1:0]          num,
	input  logic [DEN_W-1:0]          den,
	input  logic                      neg,
	output logic signed [COORD_W-1:0] res
);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;
	logic             pos_sat;
	logic             neg_sat;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
			neg_q <= neg;
		end else if (step) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	// num_q holds the quotient once all steps are done
	assign pos_sat = |num_q[NUM_W-1:COORD_W-1];
	assign neg_sat = (|num_q[NUM_W-1:COORD_W]) ||
		(num_q[COORD_W-1] && (|num_q[COORD_W-2:0]));

	always_comb begin
		if (neg_q) begin
			res = neg_sat ? {1'b1, {(COORD_W-1){1'b0}}} : -signed'(num_q[COORD_W-1:0]);
		end else begin
			res = pos_sat ? {1'b0, {(COORD_W-1){1'b1}}} : signed'(num_q[COORD_W-1:0]);
		end
	end

endmodule

// ===== src/pac_datapath.sv =====
`timescale 1ns / 1ps
// vertex registers, cross product and moment accumulators, area and centroid results
module pac_datapath
	import pac_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pac_cmd_t         cmd,
	input  vertex_t          vertex,
	input  logic [TOL_W-1:0] tol,
	output pac_stat_t        stat,
	output result_t          result
);

	logic signed [COORD_W-1:0]  in_x;
	logic signed [COORD_W-1:0]  in_y;
	logic signed [COORD_W-1:0]  first_x_q, first_y_q;
	logic signed [COORD_W-1:0]  prev_x_q, prev_y_q;
	logic signed [COORD_W-1:0]  cur_x_q, cur_y_q;
	logic signed [COORD_W-1:0]  b_x, b_y;
	logic signed [PROD_W-1:0]   p1_q, p2_q;
	logic signed [PAIR_W-1:0]   sx_q, sy_q;
	logic signed [CROSS_W-1:0]  cross_q;
	logic signed [MOMP_W-1:0]   mx_prod_q, my_prod_q;
	logic signed [AREA_W-1:0]   area_sum_q;
	logic signed [MOM_W-1:0]    mx_sum_q, my_sum_q;
	logic [AREA_W-1:0]          a2;
	logic [AREA_W:0]            a2_inc;
	logic [D3_W-1:0]            d3;
	logic [D3_W-1:0]            d3_q;
	logic [AREA_OUT_W-1:0]      area_q;
	logic signed [COORD_W-1:0]  cx_q, cy_q;
	logic signed [MOM_W-1:0]    mom_sel;
	logic [MOM_W-1:0]           mom_mag;
	logic [NUM_W-1:0]           div_num;
	logic [DEN_W-1:0]           div_den;
	logic                       div_neg;
	logic signed [COORD_W-1:0]  div_res;
	logic                       ok;

	// low coordinate bits, sign-extended
	assign in_x = COORD_W'(signed'(vertex.vertex_x[COORD_WIDTH-1:0]));
	assign in_y = COORD_W'(signed'(vertex.vertex_y[COORD_WIDTH-1:0]));

	assign b_x = cmd.use_close ? first_x_q : cur_x_q;
	assign b_y = cmd.use_close ? first_y_q : cur_y_q;

	always_ff @(posedge clk) begin
		if (cmd.load_first) begin
			first_x_q <= in_x;
			first_y_q <= in_y;
			prev_x_q  <= in_x;
			prev_y_q  <= in_y;
		end else if (cmd.shift_prev) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
		end
		if (cmd.load_cur) begin
			cur_x_q <= in_x;
			cur_y_q <= in_y;
		end
		if (cmd.mul) begin
			p1_q <= PROD_W'(prev_x_q) * PROD_W'(b_y);
			p2_q <= PROD_W'(b_x) * PROD_W'(prev_y_q);
			sx_q <= PAIR_W'(prev_x_q) + PAIR_W'(b_x);
			sy_q <= PAIR_W'(prev_y_q) + PAIR_W'(b_y);
		end
		if (cmd.xprod) begin
			cross_q <= CROSS_W'(p1_q) - CROSS_W'(p2_q);
		end
		if (cmd.mom) begin
			mx_prod_q <= MOMP_W'(sx_q) * MOMP_W'(cross_q);
			my_prod_q <= MOMP_W'(sy_q) * MOMP_W'(cross_q);
		end
		if (cmd.check) begin
			area_q <= (|a2_inc[AREA_W:AREA_OUT_W+1]) ? '1 : a2_inc[AREA_OUT_W:1];
			d3_q   <= d3;
		end
		if (cmd.store_x) begin
			cx_q <= div_res;
		end
		if (cmd.store_y) begin
			cy_q <= div_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_sum_q <= '0;
			mx_sum_q   <= '0;
			my_sum_q   <= '0;
		end else if (cmd.clear) begin
			area_sum_q <= '0;
			mx_sum_q   <= '0;
			my_sum_q   <= '0;
		end else begin
			if (cmd.mom) begin
				area_sum_q <= area_sum_q + AREA_W'(cross_q);
			end
			if (cmd.acc) begin
				mx_sum_q <= mx_sum_q + MOM_W'(mx_prod_q);
				my_sum_q <= my_sum_q + MOM_W'(my_prod_q);
			end
		end
	end

	assign a2     = area_sum_q[AREA_W-1] ? AREA_W'(-area_sum_q) : AREA_W'(area_sum_q);
	assign a2_inc = {1'b0, a2} + (AREA_W+1)'(1);
	assign d3     = {a2, 1'b0} + {1'b0, a2};

	assign stat.low_area = (a2 == '0) || (a2 < AREA_W'(tol));

	assign mom_sel = cmd.div_sel_y ? my_sum_q : mx_sum_q;
	assign mom_mag = mom_sel[MOM_W-1] ? MOM_W'(-mom_sel) : MOM_W'(mom_sel);
	assign div_num = NUM_W'({mom_mag, 1'b0}) + NUM_W'(d3_q);
	assign div_den = {d3_q, 1'b0};
	assign div_neg = mom_sel[MOM_W-1] ^ area_sum_q[AREA_W-1];

	pac_div u_div (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step),
		.num  (div_num),
		.den  (div_den),
		.neg  (div_neg),
		.res  (div_res)
	);

	assign ok = cmd.status == ST_OK;

	assign result.area       = ok ? area_q : '0;
	assign result.centroid_x = ok ? cx_q : '0;
	assign result.centroid_y = ok ? cy_q : '0;
	assign result.status     = cmd.status;

endmodule

// ===== src/pac_ctrl.sv =====
`timescale 1ns / 1ps
// controller: vertex counting, edge sequencing, division steps and result strobe
module pac_ctrl
	import pac_pkg::*;
#(
	parameter int MAX_VERTICES = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      last_vertex,
	input  pac_stat_t stat,
	output logic      busy,
	output logic      done,
	output pac_cmd_t  cmd
);

	localparam int CNT_W  = $clog2(MAX_VERTICES + 2);
	localparam int ITER_W = $clog2(DIV_STEPS);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_MUL   = 12'b0000_0000_0010,
		S_CROSS = 12'b0000_0000_0100,
		S_MOM   = 12'b0000_0000_1000,
		S_ACC   = 12'b0000_0001_0000,
		S_CHECK = 12'b0000_0010_0000,
		S_LDX   = 12'b0000_0100_0000,
		S_DIVX  = 12'b0000_1000_0000,
		S_LDY   = 12'b0001_0000_0000,
		S_DIVY  = 12'b0010_0000_0000,
		S_STY   = 12'b0100_0000_0000,
		S_EMIT  = 12'b1000_0000_0000
	} state_t;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [ITER_W-1:0] iter_q, iter_d;
	logic              last_q, last_d;
	logic              close_q, close_d;
	status_t           status_q, status_d;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		iter_d     = iter_q;
		last_d     = last_q;
		close_d    = close_q;
		status_d   = status_q;
		cmd        = '0;
		cmd.use_close = close_q;
		cmd.status = status_q;
		done       = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					last_d  = last_vertex;
					close_d = 1'b0;
					if (cnt_q == CNT_W'(MAX_VERTICES)) begin
						cnt_d = CNT_W'(MAX_VERTICES + 1);
					end else if (cnt_q == '0) begin
						cmd.load_first = 1'b1;
						cnt_d = CNT_W'(1);
					end else if (cnt_q < CNT_W'(MAX_VERTICES)) begin
						cmd.load_cur = 1'b1;
						cnt_d = CNT_W'(cnt_q + 1'b1);
					end
					if (cnt_q >= CNT_W'(MAX_VERTICES)) begin
						if (last_vertex) begin
							status_d = ST_OVERFLOW;
							state_d  = S_EMIT;
						end
					end else if (cnt_q != '0) begin
						state_d = S_MUL;
					end else if (last_vertex) begin
						close_d = 1'b1;
						state_d = S_MUL;
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CROSS;
			end
			S_CROSS: begin
				cmd.xprod = 1'b1;
				state_d = S_MOM;
			end
			S_MOM: begin
				cmd.mom = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (close_q) begin
					state_d = S_CHECK;
				end else begin
					cmd.shift_prev = 1'b1;
					if (last_q) begin
						close_d = 1'b1;
						state_d = S_MUL;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (stat.low_area) begin
					status_d = ST_LOW_AREA;
					state_d  = S_EMIT;
				end else begin
					status_d = ST_OK;
					state_d  = S_LDX;
				end
			end
			S_LDX: begin
				cmd.div_load = 1'b1;
				iter_d  = '0;
				state_d = S_DIVX;
			end
			S_DIVX: begin
				cmd.div_step = 1'b1;
				iter_d = ITER_W'(iter_q + 1'b1);
				if (iter_q == ITER_W'(DIV_STEPS - 1)) begin
					state_d = S_LDY;
				end
			end
			S_LDY: begin
				cmd.store_x   = 1'b1;
				cmd.div_load  = 1'b1;
				cmd.div_sel_y = 1'b1;
				iter_d  = '0;
				state_d = S_DIVY;
			end
			S_DIVY: begin
				cmd.div_step = 1'b1;
				iter_d = ITER_W'(iter_q + 1'b1);
				if (iter_q == ITER_W'(DIV_STEPS - 1)) begin
					state_d = S_STY;
				end
			end
			S_STY: begin
				cmd.store_y = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				done      = 1'b1;
				cmd.clear = 1'b1;
				cnt_d     = '0;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			iter_q   <= '0;
			last_q   <= 1'b0;
			close_q  <= 1'b0;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			iter_q   <= iter_d;
			last_q   <= last_d;
			close_q  <= close_d;
			status_q <= status_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

// ===== src/polygon_area_centroid.sv =====
`timescale 1ns / 1ps
// top level: apb tolerance register, controller and datapath
// a vertex that adds an edge keeps busy high through the mul, cross, mom and acc states;
// a first or ignored vertex leaves it low; a closing vertex runs the edge states, check,
// two 60-step divider passes and stores, then done pulses; a low area (twice the area zero
// or below tolerance) skips the passes; an overflow skips to done; the receiver cannot stall
// reset clears sums, vertex count and state and sets the tolerance to 1
module polygon_area_centroid
	import pac_pkg::*;
#(
	parameter int MAX_VERTICES = 256,
	parameter int COORD_WIDTH  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  vertex_t     vertex,
	output logic        done,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [TOL_W-1:0] tol_q;
	logic             tol_sel;
	pac_cmd_t         cmd;
	pac_stat_t        stat;

	assign pready  = 1'b1;
	assign tol_sel = !paddr[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_W'(1);
		end else if (psel && penable && pwrite && pready && tol_sel) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	assign prdata = tol_sel ? 64'(tol_q) : '0;

	pac_ctrl #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.last_vertex (vertex.last_vertex),
		.stat        (stat),
		.busy        (busy),
		.done        (done),
		.cmd         (cmd)
	);

	pac_datapath #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.vertex (vertex),
		.tol    (tol_q),
		.stat   (stat),
		.result (result)
	);

`ifndef SYNTHESIS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a busy period");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !vertex.last_vertex) |=> !done)
		else $error("result after a non-closing transaction");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |->
		(result.area == '0 && result.centroid_x == '0 && result.centroid_y == '0))
		else $error("error result with non-zero fields");
`endif

endmodule
